/* rtl/grid_line_of_sight_marker_top_macros.svh */
// Assertion macros shared by the grid line-of-sight marker RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef GRID_LINE_OF_SIGHT_MARKER_TOP_MACROS_SVH
`define GRID_LINE_OF_SIGHT_MARKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GLSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GLSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/glsm_pkg.sv */
// Package for the grid line-of-sight marker: field widths, commands, defaults.
// No dependencies.
package glsm_pkg;

    // Default map side in cells.
    localparam int MAP_SIDE_DEF = 64;

    // Fixed item field widths.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int CELL_W  = 2;
    localparam int VIEW_W  = 5;

    // Reset value of the view distance register.
    localparam logic [VIEW_W-1:0] VIEW_RESET = 5'd8;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRACE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CAST  = 2'd3;

    // Cell codes.
    localparam logic [CELL_W-1:0] CELL_EMPTY     = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL      = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SEEN      = 2'd2;
    localparam logic [CELL_W-1:0] CELL_SEEN_WALL = 2'd3;

endpackage

/* rtl/glsm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module glsm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_line_of_sight_marker_top.sv */
// Top level of the grid line-of-sight marker: command sequencer and ray walker.
// Depends on glsm_pkg, glsm_ram and grid_line_of_sight_marker_top_macros.svh.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  cmd, start_x, start_y, end_x, end_y, cell_value
// output    out        out_valid / out_stall read_value, ray_blocked, stop_x, stop_y
// config    in         cfg_valid / cfg_ready cfg_data (view distance)
//
// A write is done in the dispatch state; a read issues the map read there and captures
// the data in the read-wait state. A trace sets up its ray, then per visited cell does
// one map read, then the write-back and step, until a wall, the end cell or the map edge.
// A cast walks 8*(view+1) rays, each with a setup step and then the same walk; all share
// the single map port. After reset a clearing pass writes every cell empty.
// One item is worked at a time; a finished result waits in the output register while
// the next item is accepted, and the sequencer holds while that register is full and stalled.
`include "grid_line_of_sight_marker_top_macros.svh"

module grid_line_of_sight_marker_top #(
    parameter int MAP_SIDE = glsm_pkg::MAP_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [glsm_pkg::CMD_W-1:0]   cmd,
    input  logic [glsm_pkg::POS_W-1:0]   start_x,
    input  logic [glsm_pkg::POS_W-1:0]   start_y,
    input  logic [glsm_pkg::POS_W-1:0]   end_x,
    input  logic [glsm_pkg::POS_W-1:0]   end_y,
    input  logic [glsm_pkg::CELL_W-1:0]  cell_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [glsm_pkg::CELL_W-1:0]  read_value,
    output logic                         ray_blocked,
    output logic [glsm_pkg::POS_W-1:0]   stop_x,
    output logic [glsm_pkg::POS_W-1:0]   stop_y,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [glsm_pkg::VIEW_W-1:0]  cfg_data
);

    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DISP  = 3'd2;
    localparam logic [2:0] ST_RDW   = 3'd3;
    localparam logic [2:0] ST_CSET  = 3'd4;
    localparam logic [2:0] ST_RRD   = 3'd5;
    localparam logic [2:0] ST_RWB   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [glsm_pkg::VIEW_W-1:0] view_reg;

    // Latched item.
    logic [glsm_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [glsm_pkg::POS_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [glsm_pkg::POS_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic [glsm_pkg::CELL_W-1:0] val_reg, val_next;

    // Ray walker state.
    logic signed [7:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic               stx_reg, stx_next, sty_reg, sty_next;
    logic [5:0]         adx_reg, adx_next, ady_reg, ady_next;
    logic [5:0]         xi_reg, xi_next, yi_reg, yi_next;
    logic signed [15:0] e_reg, e_next;
    logic               colph_reg, colph_next;
    logic [2:0]         oct_reg, oct_next;
    logic [4:0]         col_reg, col_next;

    // Result being built.
    logic [glsm_pkg::POS_W-1:0]  lx_reg, lx_next, ly_reg, ly_next;
    logic                        blk_reg, blk_next;
    logic [glsm_pkg::CELL_W-1:0] rv_reg, rv_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [glsm_pkg::CELL_W-1:0] read_value_reg, read_value_next;
    logic                        ray_blocked_reg, ray_blocked_next;
    logic [glsm_pkg::POS_W-1:0]  stop_x_reg, stop_x_next, stop_y_reg, stop_y_next;

    // Map port.
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
    logic [glsm_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

    // Ray setup and stepping helpers.
    logic signed [7:0]  tgt_dx, tgt_dy;
    logic signed [7:0]  colv, rowv;
    logic signed [15:0] e_eff;
    logic               end_ray, end_blk;

    function automatic logic on_map(input logic signed [7:0] x, input logic signed [7:0] y);
        logic signed [9:0] xs;
        logic signed [9:0] ys;
        logic signed [9:0] side;
        xs   = {{2{x[7]}}, x};
        ys   = {{2{y[7]}}, y};
        side = 10'(MAP_SIDE);
        return (xs >= 10'sd0) && (ys >= 10'sd0) && (xs < side) && (ys < side);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [7:0] x,
                                                    input logic signed [7:0] y);
        logic [ADDR_W-1:0] ax;
        logic [ADDR_W-1:0] ay;
        ax = ADDR_W'(x[6:0]);
        ay = ADDR_W'(y[6:0]);
        return ay * ADDR_W'(MAP_SIDE) + ax;
    endfunction

    glsm_ram #(
        .WIDTH(glsm_pkg::CELL_W),
        .DEPTH(DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign ray_blocked = ray_blocked_reg;
    assign stop_x      = stop_x_reg;
    assign stop_y      = stop_y_reg;

    // Ray target offset: trace end, or a perimeter cell of the current octant.
    always_comb
    begin
        colv = {3'b000, col_reg};
        rowv = {3'b000, view_reg};
        tgt_dx = $signed({2'b00, ex_reg}) - $signed({2'b00, sx_reg});
        tgt_dy = $signed({2'b00, ey_reg}) - $signed({2'b00, sy_reg});
        if (state_reg == ST_CSET)
        begin
            case (oct_reg)
                3'd0:    begin tgt_dx = colv;  tgt_dy = rowv;  end
                3'd1:    begin tgt_dx = rowv;  tgt_dy = colv;  end
                3'd2:    begin tgt_dx = rowv;  tgt_dy = -colv; end
                3'd3:    begin tgt_dx = colv;  tgt_dy = -rowv; end
                3'd4:    begin tgt_dx = -colv; tgt_dy = rowv;  end
                3'd5:    begin tgt_dx = -rowv; tgt_dy = colv;  end
                3'd6:    begin tgt_dx = -rowv; tgt_dy = -colv; end
                default: begin tgt_dx = -colv; tgt_dy = -rowv; end
            endcase
        end
    end

    // Error term after the current cell: a column visit adds 2*|dy|.
    assign e_eff = colph_reg ? (e_reg + $signed({9'b0, ady_reg, 1'b0})) : e_reg;

    // Sequencer. A cell write-back lands before the next read is issued,
    // so consecutive visits of the same cell always see the updated value.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next = cmd_reg; sx_next = sx_reg; sy_next = sy_reg;
        ex_next = ex_reg; ey_next = ey_reg; val_next = val_reg;
        cx_next = cx_reg; cy_next = cy_reg; stx_next = stx_reg; sty_next = sty_reg;
        adx_next = adx_reg; ady_next = ady_reg; xi_next = xi_reg; yi_next = yi_reg;
        e_next = e_reg; colph_next = colph_reg; oct_next = oct_reg; col_next = col_reg;
        lx_next = lx_reg; ly_next = ly_reg; blk_next = blk_reg; rv_next = rv_reg;
        read_value_next = read_value_reg; ray_blocked_next = ray_blocked_reg;
        stop_x_next = stop_x_reg; stop_y_next = stop_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we    = 1'b0;
        mem_waddr = cell_addr(cx_reg, cy_reg);
        mem_wdata = glsm_pkg::CELL_EMPTY;
        mem_raddr = cell_addr(cx_reg, cy_reg);
        end_ray   = 1'b0;
        end_blk   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd; sx_next = start_x; sy_next = start_y;
                    ex_next = end_x; ey_next = end_y; val_next = cell_value;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                rv_next  = glsm_pkg::CELL_EMPTY;
                blk_next = 1'b0;
                lx_next  = sx_reg;
                ly_next  = sy_reg;
                cx_next  = {2'b00, sx_reg};
                cy_next  = {2'b00, sy_reg};
                if (!on_map({2'b00, sx_reg}, {2'b00, sy_reg}))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    case (cmd_reg)
                        glsm_pkg::CMD_WRITE:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cell_addr({2'b00, sx_reg}, {2'b00, sy_reg});
                            mem_wdata  = val_reg;
                            state_next = ST_FIN;
                        end
                        glsm_pkg::CMD_READ:
                        begin
                            mem_raddr  = cell_addr({2'b00, sx_reg}, {2'b00, sy_reg});
                            state_next = ST_RDW;
                        end
                        glsm_pkg::CMD_TRACE:
                        begin
                            stx_next = tgt_dx[7];
                            sty_next = tgt_dy[7];
                            adx_next = tgt_dx[7] ? 6'(-tgt_dx) : tgt_dx[5:0];
                            ady_next = tgt_dy[7] ? 6'(-tgt_dy) : tgt_dy[5:0];
                            xi_next = '0; yi_next = '0; e_next = '0; colph_next = 1'b1;
                            state_next = ST_RRD;
                        end
                        default:
                        begin
                            oct_next   = '0;
                            col_next   = '0;
                            state_next = ST_CSET;
                        end
                    endcase
                end
            end
            ST_RDW:
            begin
                rv_next    = mem_rdata;
                state_next = ST_FIN;
            end
            ST_CSET:
            begin
                cx_next  = {2'b00, sx_reg};
                cy_next  = {2'b00, sy_reg};
                stx_next = tgt_dx[7];
                sty_next = tgt_dy[7];
                adx_next = tgt_dx[7] ? 6'(-tgt_dx) : tgt_dx[5:0];
                ady_next = tgt_dy[7] ? 6'(-tgt_dy) : tgt_dy[5:0];
                xi_next = '0; yi_next = '0; e_next = '0; colph_next = 1'b1;
                state_next = ST_RRD;
            end
            ST_RRD:
            begin
                if (on_map(cx_reg, cy_reg))
                begin
                    state_next = ST_RWB;
                end
                else
                begin
                    end_ray = 1'b1;
                end
            end
            ST_RWB:
            begin
                mem_we  = 1'b1;
                lx_next = cx_reg[5:0];
                ly_next = cy_reg[5:0];
                if (mem_rdata[0])
                begin
                    // Wall or seen wall: mark it and stop.
                    mem_wdata = glsm_pkg::CELL_SEEN_WALL;
                    end_ray   = 1'b1;
                    end_blk   = 1'b1;
                end
                else
                begin
                    mem_wdata = glsm_pkg::CELL_SEEN;
                    if ((e_eff >= $signed({10'b0, adx_reg})) && (yi_reg < ady_reg))
                    begin
                        // Row step within the same column.
                        yi_next    = yi_reg + 1'b1;
                        e_next     = e_eff - $signed({9'b0, adx_reg, 1'b0});
                        cy_next    = sty_reg ? (cy_reg - 8'sd1) : (cy_reg + 8'sd1);
                        colph_next = 1'b0;
                        state_next = ST_RRD;
                    end
                    else if (xi_reg < adx_reg)
                    begin
                        // Next column.
                        e_next     = e_eff;
                        xi_next    = xi_reg + 1'b1;
                        cx_next    = stx_reg ? (cx_reg - 8'sd1) : (cx_reg + 8'sd1);
                        colph_next = 1'b1;
                        state_next = ST_RRD;
                    end
                    else
                    begin
                        e_next  = e_eff;
                        end_ray = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    read_value_next  = (cmd_reg == glsm_pkg::CMD_READ) ? rv_reg
                                                                        : glsm_pkg::CELL_EMPTY;
                    ray_blocked_next = (cmd_reg == glsm_pkg::CMD_TRACE) && blk_reg;
                    if (cmd_reg == glsm_pkg::CMD_TRACE)
                    begin
                        stop_x_next = lx_reg;
                        stop_y_next = ly_reg;
                    end
                    else if (cmd_reg == glsm_pkg::CMD_CAST)
                    begin
                        stop_x_next = sx_reg;
                        stop_y_next = sy_reg;
                    end
                    else
                    begin
                        stop_x_next = '0;
                        stop_y_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Ray finished: report a trace, or advance the cast to its next ray, ending it after the last.
        if (end_ray)
        begin
            if (cmd_reg == glsm_pkg::CMD_TRACE)
            begin
                blk_next   = end_blk;
                state_next = ST_FIN;
            end
            else if (col_reg == view_reg)
            begin
                col_next = '0;
                if (oct_reg == 3'd7)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    oct_next   = oct_reg + 1'b1;
                    state_next = ST_CSET;
                end
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                state_next = ST_CSET;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            view_reg      <= glsm_pkg::VIEW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                view_reg <= cfg_data;
            end
        end
    end

    // Payload and walker registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; sx_reg <= sx_next; sy_reg <= sy_next;
        ex_reg <= ex_next; ey_reg <= ey_next; val_reg <= val_next;
        cx_reg <= cx_next; cy_reg <= cy_next; stx_reg <= stx_next; sty_reg <= sty_next;
        adx_reg <= adx_next; ady_reg <= ady_next; xi_reg <= xi_next; yi_reg <= yi_next;
        e_reg <= e_next; colph_reg <= colph_next; oct_reg <= oct_next; col_reg <= col_next;
        lx_reg <= lx_next; ly_reg <= ly_next; blk_reg <= blk_next; rv_reg <= rv_next;
        read_value_reg <= read_value_next; ray_blocked_reg <= ray_blocked_next;
        stop_x_reg <= stop_x_next; stop_y_reg <= stop_y_next;
    end

    // Checks on the sequencer and the ray walker.
    `GLSM_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_reg == ST_DISP, "accepted item not dispatched")
    `GLSM_ASSERT_NOW(a_walk_bounds, state_reg == ST_RRD, (xi_reg <= adx_reg) && (yi_reg <= ady_reg), "ray walk counters out of range")
    `GLSM_ASSERT_NOW(a_wb_after_read, state_reg == ST_RWB, $past(state_reg) == ST_RRD, "write-back without a preceding read")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the grid line-of-sight marker: directed and random commands.
// Depends on glsm_pkg and grid_line_of_sight_marker_top; keeps its own copy of the map.
module tb_top;
    import glsm_pkg::*;

    localparam int SIDE = MAP_SIDE_DEF;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [CELL_W-1:0] read_value;
        logic              ray_blocked;
        logic [POS_W-1:0]  stop_x;
        logic [POS_W-1:0]  stop_y;
    } sight_result_t;

    // Scoreboard: a mirror of the cell map and the view register, plus pending results.
    class sight_scoreboard;
        logic [CELL_W-1:0] grid [SIDE*SIDE];
        int view_radius;
        sight_result_t pending_results[$];
        int errors;

        function new();
            foreach (grid[i]) grid[i] = CELL_EMPTY;
            view_radius = VIEW_RESET;
            errors = 0;
        endfunction

        function bit inside_map(int x, int y);
            return x >= 0 && y >= 0 && x < SIDE && y < SIDE;
        endfunction

        // Mark one cell: 0 off the map, 1 marked seen, 2 wall hit.
        function int mark_cell(int x, int y);
            int idx;
            if (!inside_map(x, y)) return 0;
            idx = y * SIDE + x;
            if (grid[idx] == CELL_SEEN_WALL || grid[idx] == CELL_WALL) begin
                grid[idx] = CELL_SEEN_WALL;
                return 2;
            end
            grid[idx] = CELL_SEEN;
            return 1;
        endfunction

        // Integer Bresenham walk with 4-connected y steps.
        function bit walk_ray(int sx, int sy, int ex, int ey, output int lx, output int ly);
            int adx, ady, stx, sty, x, y, e, cx, cy, r;
            adx = ex > sx ? ex - sx : sx - ex;
            ady = ey > sy ? ey - sy : sy - ey;
            stx = ex < sx ? -1 : 1;
            sty = ey < sy ? -1 : 1;
            y = 0;
            e = 0;
            lx = sx;
            ly = sy;
            for (x = 0; x <= adx; x++) begin
                cx = sx + stx * x;
                cy = sy + sty * y;
                r = mark_cell(cx, cy);
                if (r == 0) return 0;
                lx = cx;
                ly = cy;
                if (r == 2) return 1;
                e += 2 * ady;
                while (e >= adx && y < ady) begin
                    y++;
                    e -= 2 * adx;
                    cy = sy + sty * y;
                    r = mark_cell(cx, cy);
                    if (r == 0) return 0;
                    lx = cx;
                    ly = cy;
                    if (r == 2) return 1;
                end
            end
            return 0;
        endfunction

        // Eight octants of rays to the perimeter at the view radius.
        function void cast_fan(int sx, int sy);
            int rr, c, ox, oy, lx, ly;
            bit b;
            rr = view_radius;
            for (int o = 0; o < 8; o++) begin
                for (c = 0; c <= rr; c++) begin
                    case (o)
                        0: begin ox = c;   oy = rr;  end
                        1: begin ox = rr;  oy = c;   end
                        2: begin ox = rr;  oy = -c;  end
                        3: begin ox = c;   oy = -rr; end
                        4: begin ox = -c;  oy = rr;  end
                        5: begin ox = -rr; oy = c;   end
                        6: begin ox = -rr; oy = -c;  end
                        default: begin ox = -c; oy = -rr; end
                    endcase
                    b = walk_ray(sx, sy, sx + ox, sy + oy, lx, ly);
                end
            end
        endfunction

        // Note an accepted command and queue its expected result.
        function void note_command(logic [CMD_W-1:0] c, int sx, int sy, int ex, int ey,
                                   logic [CELL_W-1:0] val);
            sight_result_t res;
            int lx, ly;
            res = '0;
            case (c)
                CMD_WRITE: grid[sy * SIDE + sx] = val;
                CMD_READ: res.read_value = grid[sy * SIDE + sx];
                CMD_TRACE: begin
                    res.ray_blocked = walk_ray(sx, sy, ex, ey, lx, ly);
                    res.stop_x = lx;
                    res.stop_y = ly;
                end
                default: begin
                    cast_fan(sx, sy);
                    res.stop_x = sx;
                    res.stop_y = sy;
                end
            endcase
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(sight_result_t got);
            sight_result_t exp_res;
            if (pending_results.size() == 0) begin
                $error("result with no expectation pending");
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.read_value !== exp_res.read_value) begin
                $error("read_value expected %0d actual %0d", exp_res.read_value, got.read_value);
                errors++;
            end
            if (got.ray_blocked !== exp_res.ray_blocked) begin
                $error("ray_blocked expected %0d actual %0d", exp_res.ray_blocked,
                       got.ray_blocked);
                errors++;
            end
            if (got.stop_x !== exp_res.stop_x) begin
                $error("stop_x expected %0d actual %0d", exp_res.stop_x, got.stop_x);
                errors++;
            end
            if (got.stop_y !== exp_res.stop_y) begin
                $error("stop_y expected %0d actual %0d", exp_res.stop_y, got.stop_y);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CMD_W-1:0] cmd = '0;
    logic [POS_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [CELL_W-1:0] cell_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CELL_W-1:0] read_value;
    logic ray_blocked;
    logic [POS_W-1:0] stop_x, stop_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [VIEW_W-1:0] cfg_data = '0;

    sight_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int commands_sent = 0;
    int results_seen = 0;

    grid_line_of_sight_marker_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y), .cell_value(cell_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .ray_blocked(ray_blocked),
        .stop_x(stop_x), .stop_y(stop_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stall, check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result('{read_value, ray_blocked, stop_x, stop_y});
            results_seen++;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no accepted item; covers the clearing pass and long casts.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one command, with an optional random gap before it. Valid stays high after
    // acceptance until the next gap or the next command replaces the item.
    task automatic send_command(logic [CMD_W-1:0] c, int sx, int sy, int ex, int ey,
                                logic [CELL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        cell_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(c, sx, sy, ex, ey, val);
        commands_sent++;
    endtask

    // Wait for all results, then write the view distance.
    task automatic write_view(int v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.view_radius = v;
    endtask

    // Random commands, weighted toward building walls then tracing through them.
    task automatic random_phase(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 35)
                send_command(CMD_WRITE, $urandom_range(63), $urandom_range(63), 0, 0,
                             ($urandom_range(3) == 0) ? $urandom_range(3) : CELL_WALL);
            else if (kind < 60)
                send_command(CMD_READ, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63), $urandom_range(3));
            else if (kind < 93)
                send_command(CMD_TRACE, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63), $urandom_range(3));
            else
                send_command(CMD_CAST, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63), $urandom_range(3));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, each command, wall at origin, degenerate ray, map edges.
        send_command(CMD_WRITE, 0, 0, 63, 63, 2'd1);
        send_command(CMD_READ, 0, 0, 0, 0, 2'd0);
        send_command(CMD_TRACE, 0, 0, 63, 63, 2'd0);
        send_command(CMD_READ, 0, 0, 0, 0, 2'd3);
        send_command(CMD_TRACE, 5, 5, 5, 5, 2'd0);
        send_command(CMD_WRITE, 63, 63, 0, 0, 2'd3);
        send_command(CMD_TRACE, 10, 10, 63, 63, 2'd0);
        send_command(CMD_WRITE, 40, 2, 0, 0, 2'd2);
        send_command(CMD_TRACE, 63, 0, 0, 63, 2'd0);
        send_command(CMD_TRACE, 20, 63, 20, 0, 2'd0);
        send_command(CMD_TRACE, 32, 32, 33, 63, 2'd0);
        send_command(CMD_READ, 63, 63, 0, 0, 2'd0);
        send_command(CMD_WRITE, 30, 30, 0, 0, 2'd0);
        send_command(CMD_CAST, 0, 63, 0, 0, 2'd0);
        send_command(CMD_CAST, 32, 32, 63, 63, 2'd0);
        write_view(1);
        send_command(CMD_CAST, 63, 0, 0, 0, 2'd0);
        write_view(31);
        send_command(CMD_CAST, 31, 31, 0, 0, 2'd0);
        write_view(0);
        send_command(CMD_CAST, 10, 50, 0, 0, 2'd0);
        send_command(CMD_READ, 10, 50, 0, 0, 2'd0);
        write_view($urandom_range(2, 12));

        // Random part in three idling regimes.
        send_idle_pct = 8;
        recv_stall_pct = 47;
        random_phase(26);
        send_idle_pct = 47;
        recv_stall_pct = 8;
        random_phase(26);
        write_view($urandom_range(1, 31));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(26);
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d commands (write, read, trace, cast) with %0d results checked,",
                 commands_sent, results_seen);
        $display("view distance swept over 0, 1, 31 and random values.");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
